### design/segic_pkg.sv
// Package for the segment intersection connectivity block.
// Holds operation and status codes, field widths and the controller/datapath structs.
// No dependencies.
`default_nettype none

package segic_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_SEGMENTS_DEF = 16;
    localparam int COORD_BITS_DEF   = 16;

    // Fixed field widths
    localparam int OP_W     = 2;
    localparam int FIELD_W  = 16;
    localparam int QIDX_W   = 4;
    localparam int STATUS_W = 2;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;  // no operation, answers ok

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SET_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNUSED    = 2'd3;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;        // capture the input transaction
        logic clear;       // empty the set
        logic add_start;   // store new segment, init its row
        logic mul;         // capture stored segment and cross products
        logic cmp;         // apply touch test, advance index
        logic add_fin;     // bump count, mark closure stale
        logic close_start; // reset sweep index
        logic close_step;  // fold one pivot row into every row that links to the pivot
        logic close_fin;   // mark closure current
        logic res_ok;      // result: ok, not connected
        logic res_full;    // result: set full
        logic qry;         // result: query answer
        logic out_load;    // move result into output register
    } segic_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            count_zero;
        logic            idx_last;
        logic            k_last;
        logic            current;
    } segic_sts_t;

endpackage

`default_nettype wire

### design/segment_intersection_connectivity.sv
// Top level of the segment intersection connectivity block.
// Depends on segic_pkg, segic_ctrl, segic_dp (which holds segic_ram).
`default_nettype none

// Holds up to MAX_SEGMENTS segments and their link matrix; one result per input
// transaction, one transaction in work at a time. Clear, a rejected add and an
// unused code go from decode straight to the result. An add visits each stored
// segment in turn through the one shared cross-product unit (RAM read, multiply,
// compare). A query first runs the closure sweep, one pivot row per cycle, when
// an add has happened since the last closure. Another transaction is accepted
// while a finished result still waits in the output register.
module segment_intersection_connectivity
    import segic_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // [15:0] start_x, [31:16] start_y, [47:32] end_x, [63:48] end_y,
    // [67:64] first_index, [71:68] second_index
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // [1:0] operation
    input  wire logic [OP_W-1:0]        s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [0] connected, [2:1] status, [7:3] zero
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    segic_cmd_t cmd;
    segic_sts_t sts;

    segic_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    segic_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .COORD_BITS   (COORD_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_op    (s_tuser),
        .in_data  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (m_tdata)
    );

endmodule

`default_nettype wire

### design/segic_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module segic_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### design/segic_ctrl.sv
// Controller state machine for the segment intersection connectivity block.
// Depends on segic_pkg; drives segic_dp through segic_cmd_t.
`default_nettype none

module segic_ctrl
    import segic_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    input  wire segic_sts_t sts,
    output segic_cmd_t      cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DEC     = 4'd1;
    localparam logic [3:0] S_ADD_RD  = 4'd2;
    localparam logic [3:0] S_ADD_MUL = 4'd3;
    localparam logic [3:0] S_ADD_CMP = 4'd4;
    localparam logic [3:0] S_ADD_FIN = 4'd5;
    localparam logic [3:0] S_CLOSE   = 4'd6;
    localparam logic [3:0] S_QRY     = 4'd7;
    localparam logic [3:0] S_RESP    = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       mvalid_reg, mvalid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                unique case (sts.op)
                    OP_CLEAR:
                    begin
                        cmd.clear  = 1'b1;
                        cmd.res_ok = 1'b1;
                        state_next = S_RESP;
                    end
                    OP_ADD:
                    begin
                        if (sts.full)
                        begin
                            cmd.res_full = 1'b1;
                            state_next   = S_RESP;
                        end
                        else
                        begin
                            cmd.add_start = 1'b1;
                            state_next    = sts.count_zero ? S_ADD_FIN : S_ADD_RD;
                        end
                    end
                    OP_QUERY:
                    begin
                        if (sts.current)
                        begin
                            state_next = S_QRY;
                        end
                        else if (sts.count_zero)
                        begin
                            cmd.close_fin = 1'b1;
                            state_next    = S_QRY;
                        end
                        else
                        begin
                            cmd.close_start = 1'b1;
                            state_next      = S_CLOSE;
                        end
                    end
                    default:
                    begin
                        cmd.res_ok = 1'b1;
                        state_next = S_RESP;
                    end
                endcase
            end
            S_ADD_RD:
            begin
                state_next = S_ADD_MUL;
            end
            S_ADD_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ADD_CMP;
            end
            S_ADD_CMP:
            begin
                cmd.cmp    = 1'b1;
                state_next = sts.idx_last ? S_ADD_FIN : S_ADD_RD;
            end
            S_ADD_FIN:
            begin
                cmd.add_fin = 1'b1;
                cmd.res_ok  = 1'b1;
                state_next  = S_RESP;
            end
            S_CLOSE:
            begin
                cmd.close_step = 1'b1;
                if (sts.k_last)
                begin
                    cmd.close_fin = 1'b1;
                    state_next    = S_QRY;
                end
            end
            S_QRY:
            begin
                cmd.qry    = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid flag
    always_comb
    begin
        if (cmd.out_load)
        begin
            mvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            mvalid_next = 1'b0;
        end
        else
        begin
            mvalid_next = mvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule

`default_nettype wire

### design/segic_dp.sv
// Datapath: segment store, cross-product unit, link matrix, closure sweep, result regs.
// Depends on segic_pkg and segic_ram; controlled by segic_ctrl.
`default_nettype none

module segic_dp
    import segic_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [OP_W-1:0]       in_op,
    input  wire logic [IN_TDATA_W-1:0] in_data,
    input  wire segic_cmd_t            cmd,
    output segic_sts_t                 sts,
    output logic [OUT_TDATA_W-1:0]     out_data
);

    localparam int CW   = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
    localparam int DW   = CW + 1;
    localparam int PW   = 2 * DW;
    localparam int SW   = 4 * CW;
    localparam int IW   = $clog2(MAX_SEGMENTS);
    localparam int CNTW = $clog2(MAX_SEGMENTS + 1);
    localparam int CMPW = (CNTW > QIDX_W) ? CNTW : QIDX_W;

    // Captured transaction
    logic [OP_W-1:0]   op_reg;
    logic [SW-1:0]     seg_reg;      // {ey, ex, sy, sx}
    logic [QIDX_W-1:0] q1_reg, q2_reg;

    // Control state
    logic [CNTW-1:0]         count_reg;
    logic                    current_reg;
    logic [IW-1:0]           idx_reg, k_reg;
    logic [MAX_SEGMENTS-1:0] link_reg [MAX_SEGMENTS];

    // Compare pipeline
    logic [SW-1:0]   st_reg;
    logic signed [PW-1:0] p_reg [4];
    logic signed [PW-1:0] q_reg [4];

    // Result
    logic                conn_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                oconn_reg;
    logic [STATUS_W-1:0] ostatus_reg;

    logic [SW-1:0] ram_rdata;

    // Segment store
    segic_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_SEGMENTS)
    ) u_store (
        .clk   (clk),
        .we    (cmd.add_start),
        .waddr (count_reg[IW-1:0]),
        .wdata (seg_reg),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // Capture of input fields, low CW bits of each coordinate
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= in_op;
            seg_reg <= {in_data[48 +: CW], in_data[32 +: CW],
                        in_data[16 +: CW], in_data[0 +: CW]};
            q1_reg  <= in_data[64 +: QIDX_W];
            q2_reg  <= in_data[68 +: QIDX_W];
        end
    end

    // Coordinates widened by one bit: s = new segment, t = stored segment
    logic signed [DW-1:0] sax, say, sbx, sby, tax, tay, tbx, tby;
    assign sax = {seg_reg[CW-1],      seg_reg[0 +: CW]};
    assign say = {seg_reg[2*CW-1],    seg_reg[CW +: CW]};
    assign sbx = {seg_reg[3*CW-1],    seg_reg[2*CW +: CW]};
    assign sby = {seg_reg[4*CW-1],    seg_reg[3*CW +: CW]};
    assign tax = {st_reg[CW-1],       st_reg[0 +: CW]};
    assign tay = {st_reg[2*CW-1],     st_reg[CW +: CW]};
    assign tbx = {st_reg[3*CW-1],     st_reg[2*CW +: CW]};
    assign tby = {st_reg[4*CW-1],     st_reg[3*CW +: CW]};

    // Stored segment straight from RAM for the multiply stage
    logic signed [DW-1:0] rax, ray, rbx, rby;
    assign rax = {ram_rdata[CW-1],   ram_rdata[0 +: CW]};
    assign ray = {ram_rdata[2*CW-1], ram_rdata[CW +: CW]};
    assign rbx = {ram_rdata[3*CW-1], ram_rdata[2*CW +: CW]};
    assign rby = {ram_rdata[4*CW-1], ram_rdata[3*CW +: CW]};

    // Cross products: side(a,b,c) compares (c.x-a.x)(b.y-a.y) with (b.x-a.x)(c.y-a.y)
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            st_reg   <= ram_rdata;
            // new start against stored line
            p_reg[0] <= PW'(sax - rax) * PW'(rby - ray);
            q_reg[0] <= PW'(rbx - rax) * PW'(say - ray);
            // new end against stored line
            p_reg[1] <= PW'(sbx - rax) * PW'(rby - ray);
            q_reg[1] <= PW'(rbx - rax) * PW'(sby - ray);
            // stored start against new line
            p_reg[2] <= PW'(rax - sax) * PW'(sby - say);
            q_reg[2] <= PW'(sbx - sax) * PW'(ray - say);
            // stored end against new line
            p_reg[3] <= PW'(rbx - sax) * PW'(sby - say);
            q_reg[3] <= PW'(sbx - sax) * PW'(rby - say);
        end
    end

    // Touch test
    logic [3:0] pos, neg, zer;
    logic       on_t_a, on_t_b, on_s_a, on_s_b, touch;

    function automatic logic in_box(
        input logic signed [DW-1:0] ax, ay, bx, by, cx, cy
    );
        logic signed [DW-1:0] lx, hx, ly, hy;
        begin
            lx = (ax < bx) ? ax : bx;
            hx = (ax < bx) ? bx : ax;
            ly = (ay < by) ? ay : by;
            hy = (ay < by) ? by : ay;
            in_box = (lx <= cx) && (cx <= hx) && (ly <= cy) && (cy <= hy);
        end
    endfunction

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            pos[j] = p_reg[j] > q_reg[j];
            neg[j] = p_reg[j] < q_reg[j];
            zer[j] = !pos[j] && !neg[j];
        end
        on_t_a = zer[0] && in_box(tax, tay, tbx, tby, sax, say);
        on_t_b = zer[1] && in_box(tax, tay, tbx, tby, sbx, sby);
        on_s_a = zer[2] && in_box(sax, say, sbx, sby, tax, tay);
        on_s_b = zer[3] && in_box(sax, say, sbx, sby, tbx, tby);
        touch  = (((pos[0] && neg[1]) || (neg[0] && pos[1]))
                  && ((pos[2] && neg[3]) || (neg[2] && pos[3])))
                 || on_t_a || on_t_b || on_s_a || on_s_b;
    end

    // Pivot row for the closure sweep
    logic [MAX_SEGMENTS-1:0] pivot_row;
    always_comb
    begin
        pivot_row = '0;
        for (int i = 0; i < MAX_SEGMENTS; i++)
        begin
            if (IW'(i) == k_reg)
            begin
                pivot_row = link_reg[i];
            end
        end
    end

    // Link matrix
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SEGMENTS; i++)
            begin
                link_reg[i] <= '0;
            end
        end
        else if (cmd.clear)
        begin
            for (int i = 0; i < MAX_SEGMENTS; i++)
            begin
                link_reg[i] <= '0;
            end
        end
        else if (cmd.add_start)
        begin
            for (int i = 0; i < MAX_SEGMENTS; i++)
            begin
                if (CNTW'(i) == count_reg)
                begin
                    link_reg[i] <= MAX_SEGMENTS'(1) << i;
                end
            end
        end
        else if (cmd.cmp && touch)
        begin
            // symmetric link between new row (count) and stored row (idx)
            for (int i = 0; i < MAX_SEGMENTS; i++)
            begin
                if (CNTW'(i) == count_reg)
                begin
                    link_reg[i][idx_reg] <= 1'b1;
                end
                if (IW'(i) == idx_reg)
                begin
                    link_reg[i][count_reg[IW-1:0]] <= 1'b1;
                end
            end
        end
        else if (cmd.close_step)
        begin
            for (int i = 0; i < MAX_SEGMENTS; i++)
            begin
                if (link_reg[i][k_reg])
                begin
                    link_reg[i] <= link_reg[i] | pivot_row;
                end
            end
        end
    end

    // Count, closure flag and sweep indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            current_reg <= 1'b1;
            idx_reg     <= '0;
            k_reg       <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                count_reg   <= '0;
                current_reg <= 1'b1;
            end
            else if (cmd.add_fin)
            begin
                count_reg   <= count_reg + CNTW'(1);
                current_reg <= 1'b0;
            end
            else if (cmd.close_fin)
            begin
                current_reg <= 1'b1;
            end

            if (cmd.add_start)
            begin
                idx_reg <= '0;
            end
            else if (cmd.cmp)
            begin
                idx_reg <= idx_reg + IW'(1);
            end

            if (cmd.close_start)
            begin
                k_reg <= '0;
            end
            else if (cmd.close_step)
            begin
                k_reg <= k_reg + IW'(1);
            end
        end
    end

    // Query lookup
    logic [CMPW-1:0]         q1_ext, q2_ext, cnt_ext;
    logic                    q_in_range;
    logic [MAX_SEGMENTS-1:0] q_row;
    logic                    q_bit;
    assign q1_ext     = CMPW'(q1_reg);
    assign q2_ext     = CMPW'(q2_reg);
    assign cnt_ext    = CMPW'(count_reg);
    assign q_in_range = (q1_ext < cnt_ext) && (q2_ext < cnt_ext);

    always_comb
    begin
        q_row = '0;
        q_bit = 1'b0;
        for (int i = 0; i < MAX_SEGMENTS; i++)
        begin
            if (CMPW'(i) == q1_ext)
            begin
                q_row = link_reg[i];
            end
        end
        for (int j = 0; j < MAX_SEGMENTS; j++)
        begin
            if (CMPW'(j) == q2_ext)
            begin
                q_bit = q_row[j];
            end
        end
    end

    // Result and output registers
    always_ff @(posedge clk)
    begin
        if (cmd.res_ok)
        begin
            conn_reg   <= 1'b0;
            status_reg <= ST_OK;
        end
        else if (cmd.res_full)
        begin
            conn_reg   <= 1'b0;
            status_reg <= ST_SET_FULL;
        end
        else if (cmd.qry)
        begin
            conn_reg   <= q_in_range && q_bit;
            status_reg <= q_in_range ? ST_OK : ST_BAD_INDEX;
        end
        if (cmd.out_load)
        begin
            oconn_reg   <= conn_reg;
            ostatus_reg <= status_reg;
        end
    end

    assign out_data = {{(OUT_TDATA_W - STATUS_W - 1){1'b0}}, ostatus_reg, oconn_reg};

    // Status to controller
    always_comb
    begin
        sts.op         = op_reg;
        sts.full       = (count_reg == CNTW'(MAX_SEGMENTS));
        sts.count_zero = (count_reg == '0);
        sts.idx_last   = (CNTW'(idx_reg) == count_reg - CNTW'(1));
        sts.k_last     = (CNTW'(k_reg) == count_reg - CNTW'(1));
        sts.current    = current_reg;
    end

endmodule

`default_nettype wire

### design/segic_checker.sv
// Port-level checker for segment_intersection_connectivity, with its bind.
// Depends on segic_pkg.
`default_nettype none

module segic_checker
    import segic_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_tvalid,
    input wire logic                   s_tready,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [OUT_TDATA_W-1:0] m_tdata
);

    // A held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One transaction in work at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice in a row");

    // Status code is never the unused one
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:1] != ST_UNUSED)
        else $error("unused status code");

    // Error results never report a link
    a_err_unlinked: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:1] != ST_OK) |-> !m_tdata[0])
        else $error("link reported with error status");

endmodule

bind segment_intersection_connectivity segic_checker u_segic_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
